// ===== sv/rmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and the CRC function of the read-master framer
// Result kinds, register indexes, the receive report and the CRC-16 step.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [1:0] {
    KIND_REQ     = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CRC_ERR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_SLAVE    = 2'd0,
    REG_FUNCTION = 2'd1,
    REG_START    = 2'd2,
    REG_QUANTITY = 2'd3
  } reg_index_t;

  // frame-end report from the receive checker
  typedef struct packed {
    logic        good;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [7:0]  count;
    logic [15:0] crc_rx;
    logic [15:0] crc_local;
  } report_t;

  // one byte of the reflected CRC-16, all eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== sv/modbus_rtu_read_master_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_read_master_framer: Modbus RTU read request framer and
// response checker
//   Input channel (in_valid/in_stall): mode 0 asks for one 8-byte read
//   request; mode 1 carries one received response byte in rx_byte.
//   Output channel (out_valid/out_stall): request bytes (kind 0, last on the
//   CRC high byte) and one frame-end report per response (kind 1 good,
//   kind 2 CRC error, last set, header and both CRCs).
//   A frame-end report is registered into the output in the cycle after its
//   final byte is taken; a taken request first sets the sequencer active.
//   Response bytes are taken one per cycle unless stalled; the sequencer emits
//   one byte per cycle into the output register while it is not stalled,
//   running the CRC over the six header bytes as it goes, and takes the next
//   request only after its eighth byte. Response bytes that end no frame are
//   taken even while a request drains; a frame-end byte and a new request
//   wait for the sequencer. Reset restores the register defaults (slave 1,
//   function 3, start 0, quantity 5) and starts a fresh response frame.
//   A stalled output holds its request; input is then stalled only when an
//   item needs the output register.
// ----------------------------------------------------------------------------
module modbus_rtu_read_master_framer import rmf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [7:0]  resp_slave,
  output logic [7:0]  resp_function,
  output logic [7:0]  resp_count,
  output logic [15:0] crc_received,
  output logic [15:0] crc_computed
);

  logic [7:0]  slave_address;
  logic [7:0]  function_code;
  logic [15:0] start_register;
  logic [15:0] register_quantity;

  logic        seq_active;
  logic [2:0]  seq_idx;
  logic [15:0] seq_crc;
  logic [7:0]  req_byte;

  logic        out_free;
  logic        in_accept;
  logic        rx_take;
  logic        frame_end;
  report_t     report;
  logic        seq_emit;
  logic        rpt_emit;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = mode ? (frame_end && (seq_active || !out_free)) : seq_active;
  assign in_accept = in_valid && !in_stall;
  assign rx_take   = in_accept && mode;
  assign seq_emit  = seq_active && out_free;
  assign rpt_emit  = rx_take && frame_end;

  rmf_rx_check u_rx_check (
    .clk       (clk),
    .rst       (rst),
    .take      (rx_take),
    .rx_byte   (rx_byte),
    .frame_end (frame_end),
    .report    (report)
  );

  always_comb begin
    unique case (seq_idx)
      3'd0:    req_byte = slave_address;
      3'd1:    req_byte = function_code;
      3'd2:    req_byte = start_register[15:8];
      3'd3:    req_byte = start_register[7:0];
      3'd4:    req_byte = register_quantity[15:8];
      3'd5:    req_byte = register_quantity[7:0];
      3'd6:    req_byte = seq_crc[7:0];
      default: req_byte = seq_crc[15:8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address     <= 8'd1;
      function_code     <= 8'd3;
      start_register    <= 16'd0;
      register_quantity <= 16'd5;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_SLAVE:    slave_address     <= cfg_data[7:0];
        REG_FUNCTION: function_code     <= cfg_data[7:0];
        REG_START:    start_register    <= cfg_data;
        REG_QUANTITY: register_quantity <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active <= 1'b0;
      seq_idx    <= '0;
      seq_crc    <= CRC_INIT;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept && !mode) begin
        seq_active <= 1'b1;
        seq_idx    <= '0;
        seq_crc    <= CRC_INIT;
      end else if (seq_emit) begin
        seq_idx <= seq_idx + 3'd1;
        if (seq_idx == 3'd7) seq_active <= 1'b0;
        if (seq_idx < 3'd6) seq_crc <= crc_byte(seq_crc, req_byte);
      end
      if (seq_emit || rpt_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (seq_emit) begin
      kind          <= KIND_REQ;
      tx_byte       <= req_byte;
      last          <= (seq_idx == 3'd7);
      resp_slave    <= '0;
      resp_function <= '0;
      resp_count    <= '0;
      crc_received  <= '0;
      crc_computed  <= '0;
    end else if (rpt_emit) begin
      kind          <= report.good ? KIND_GOOD : KIND_CRC_ERR;
      tx_byte       <= '0;
      last          <= 1'b1;
      resp_slave    <= report.slave;
      resp_function <= report.func;
      resp_count    <= report.count;
      crc_received  <= report.crc_rx;
      crc_computed  <= report.crc_local;
    end
  end

endmodule

// ===== sv/rmf_rx_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_rx_check: response frame tracker and CRC check
// Follows byte position, holds the header, accumulates the CRC and builds
// the report for the frame's final byte.
// ----------------------------------------------------------------------------
module rmf_rx_check import rmf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       frame_end,
  output report_t    report
);

  logic [8:0]  byte_position;
  logic [7:0]  declared_count;
  logic [15:0] running_crc;
  logic [7:0]  held_slave;
  logic [7:0]  held_function;
  logic [7:0]  crc_low_byte;

  logic [8:0]  crc_pos;
  logic        in_body;
  logic        crc_slot;
  logic [15:0] rx_crc;

  assign crc_pos   = 9'd3 + {1'b0, declared_count};
  assign in_body   = (byte_position <= 9'd2) || (byte_position < crc_pos);
  assign crc_slot  = (byte_position == crc_pos);
  assign frame_end = !in_body && !crc_slot;
  assign rx_crc    = {rx_byte, crc_low_byte};

  assign report.good      = (rx_crc == running_crc);
  assign report.slave     = held_slave;
  assign report.func      = held_function;
  assign report.count     = declared_count;
  assign report.crc_rx    = rx_crc;
  assign report.crc_local = running_crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      declared_count <= '0;
      running_crc    <= CRC_INIT;
      held_slave     <= '0;
      held_function  <= '0;
      crc_low_byte   <= '0;
    end else if (take) begin
      if (in_body) begin
        if (byte_position == 9'd0) held_slave <= rx_byte;
        if (byte_position == 9'd1) held_function <= rx_byte;
        if (byte_position == 9'd2) declared_count <= rx_byte;
        running_crc   <= crc_byte(running_crc, rx_byte);
        byte_position <= byte_position + 9'd1;
      end else if (crc_slot) begin
        crc_low_byte  <= rx_byte;
        byte_position <= byte_position + 9'd1;
      end else begin
        byte_position <= '0;
        running_crc   <= CRC_INIT;
      end
    end
  end

endmodule

// ===== verif/tb_modbus_rtu_read_master_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_read_master_framer: self-checking bench for the read framer
// Drives read requests and response bytes through the valid/stall input,
// predicts every request byte and frame-end report in the bench, and checks
// each accepted output against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_read_master_framer;
  import rmf_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  typedef struct {
    kind_t       kind;
    logic [7:0]  tx;
    logic        last;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [7:0]  count;
    logic [15:0] crc_rx;
    logic [15:0] crc_local;
  } framer_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [7:0]  resp_slave;
  logic [7:0]  resp_function;
  logic [7:0]  resp_count;
  logic [15:0] crc_received;
  logic [15:0] crc_computed;

  // bench copy of the registers and of the receive state
  logic [7:0]  addr_cfg  = 8'd1;
  logic [7:0]  func_cfg  = 8'd3;
  logic [15:0] start_cfg = 16'd0;
  logic [15:0] qty_cfg   = 16'd5;
  logic [8:0]  rx_pos    = '0;
  logic [7:0]  rx_count  = '0;
  logic [15:0] rx_crc    = CRC_INIT;
  logic [7:0]  rx_slave  = '0;
  logic [7:0]  rx_func   = '0;
  logic [7:0]  rx_crc_lo = '0;

  framer_result_t due_results[$];
  int errors     = 0;
  int items_sent = 0;
  int hold_left  = 0;
  int quiet      = 0;
  bit send_gaps  = 1'b1;
  bit recv_idle  = 1'b1;

  modbus_rtu_read_master_framer DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .tx_byte      (tx_byte),
    .last         (last),
    .resp_slave   (resp_slave),
    .resp_function(resp_function),
    .resp_count   (resp_count),
    .crc_received (crc_received),
    .crc_computed (crc_computed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // bit-serial form of the reflected CRC-16
  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] d);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ d[i];
      acc = acc >> 1;
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic framer_result_t make_result(kind_t k, logic [7:0] tx, logic lst,
                                                 logic [7:0] s, logic [7:0] f,
                                                 logic [7:0] c, logic [15:0] cr,
                                                 logic [15:0] cc);
    framer_result_t r;
    r.kind      = k;
    r.tx        = tx;
    r.last      = lst;
    r.slave     = s;
    r.func      = f;
    r.count     = c;
    r.crc_rx    = cr;
    r.crc_local = cc;
    return r;
  endfunction

  function automatic void predict_framer(logic m, logic [7:0] b);
    logic [7:0]  hdr[8];
    logic [15:0] c;
    logic [15:0] got;
    logic [8:0]  crc_at;
    if (!m) begin
      hdr[0] = addr_cfg;
      hdr[1] = func_cfg;
      hdr[2] = start_cfg[15:8];
      hdr[3] = start_cfg[7:0];
      hdr[4] = qty_cfg[15:8];
      hdr[5] = qty_cfg[7:0];
      c = CRC_INIT;
      for (int i = 0; i < 6; i++) c = crc16_step(c, hdr[i]);
      hdr[6] = c[7:0];
      hdr[7] = c[15:8];
      for (int i = 0; i < 8; i++)
        due_results.push_back(make_result(KIND_REQ, hdr[i], i == 7, '0, '0, '0, '0, '0));
    end else begin
      crc_at = 9'd3 + {1'b0, rx_count};
      if (rx_pos <= 9'd2 || rx_pos < crc_at) begin
        if (rx_pos == 9'd0) rx_slave = b;
        else if (rx_pos == 9'd1) rx_func = b;
        else if (rx_pos == 9'd2) rx_count = b;
        rx_crc = crc16_step(rx_crc, b);
        rx_pos = rx_pos + 9'd1;
      end else if (rx_pos == crc_at) begin
        rx_crc_lo = b;
        rx_pos = rx_pos + 9'd1;
      end else begin
        got = {b, rx_crc_lo};
        due_results.push_back(make_result(got == rx_crc ? KIND_GOOD : KIND_CRC_ERR, '0,
                                          1'b1, rx_slave, rx_func, rx_count, got, rx_crc));
        rx_pos = '0;
        rx_crc = CRC_INIT;
      end
    end
  endfunction

  function automatic void cmp_field(string name, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_out
    framer_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("kind: expected none, actual 0x%0h", kind);
        errors++;
      end else begin
        e = due_results.pop_front();
        cmp_field("kind", e.kind, kind);
        cmp_field("tx_byte", e.tx, tx_byte);
        cmp_field("last", e.last, last);
        cmp_field("resp_slave", e.slave, resp_slave);
        cmp_field("resp_function", e.func, resp_function);
        cmp_field("resp_count", e.count, resp_count);
        cmp_field("crc_received", e.crc_rx, crc_received);
        cmp_field("crc_computed", e.crc_local, crc_computed);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("modbus_rtu_read_master_framer: mismatch");
      $finish;
    end else begin
      quiet++;
    end
  end

  // receiver: random stall bursts plus a long hold-off on request
  initial begin : receiver
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (recv_idle && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input logic m, input logic [7:0] b);
    in_valid <= 1'b1;
    mode     <= m;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_framer(m, b);
    items_sent++;
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  // interleave: 0 none, 1 random requests, 2 one request before the CRC high byte
  task automatic send_frame(input int count, input bit good, input int interleave,
                            input int fill);
    logic [7:0]  bytes[$];
    logic [15:0] c;
    bytes.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    bytes.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    bytes.push_back(8'(count));
    repeat (count) bytes.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
    c = CRC_INIT;
    foreach (bytes[j]) c = crc16_step(c, bytes[j]);
    if (!good) c = c ^ 16'($urandom_range(1, 65535));
    bytes.push_back(c[7:0]);
    bytes.push_back(c[15:8]);
    foreach (bytes[j]) begin
      if ((interleave == 1 && $urandom_range(0, 5) == 0) ||
          (interleave == 2 && j == bytes.size() - 1))
        send_item(1'b0, 8'($urandom_range(0, 255)));
      send_item(1'b1, bytes[j]);
    end
  endtask

  // finish any partial frame so the next one starts aligned
  task automatic align_frame();
    while (rx_pos != 9'd0) send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SLAVE:    addr_cfg  = val[7:0];
      REG_FUNCTION: func_cfg  = val[7:0];
      REG_START:    start_cfg = val;
      REG_QUANTITY: qty_cfg   = val;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all(input logic [15:0] s, input logic [15:0] f,
                           input logic [15:0] st, input logic [15:0] q);
    settle();
    write_reg(REG_SLAVE, s);
    write_reg(REG_FUNCTION, f);
    write_reg(REG_START, st);
    write_reg(REG_QUANTITY, q);
  endtask

  task automatic test_reset_defaults();
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
  endtask

  task automatic test_register_extremes();
    write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(1'b0, 8'h5A);
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, 8'hA5);
    write_all(16'h0011, 16'h0004, 16'h1234, 16'h00FF);
    send_item(1'b0, 8'h00);
  endtask

  task automatic test_short_frames();
    send_frame(0, 1'b1, 0, -1);
    send_frame(0, 1'b0, 0, -1);
    send_frame(1, 1'b1, 0, 8'hFF);
    send_frame(2, 1'b1, 2, 8'h00);
    send_frame(1, 1'b0, 1, -1);
  endtask

  task automatic test_long_frame();
    send_frame(120, 1'b1, 0, -1);
  endtask

  task automatic test_stalled_output();
    settle();
    hold_left = 300;
    repeat (12) send_item(1'b0, 8'($urandom_range(0, 255)));
    send_frame(3, 1'b1, 0, -1);
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int pick;
    logic [15:0] val;
    stop_at = items_sent + 50;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_item(1'b0, 8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
        align_frame();
        send_frame($urandom_range(0, 3) == 0 ? $urandom_range(0, 20) : $urandom_range(0, 6),
                   $urandom_range(0, 3) != 0, $urandom_range(0, 1), -1);
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) send_item(1'b1, 8'($urandom_range(0, 255)));
      end else begin
        settle();
        case ($urandom_range(0, 2))
          0:       val = 16'h0000;
          1:       val = 16'hFFFF;
          default: val = 16'($urandom_range(0, 65535));
        endcase
        write_reg(reg_index_t'($urandom_range(0, 3)), val);
      end
    end
    align_frame();
  endtask

  task automatic test_full_rate();
    send_gaps = 1'b0;
    recv_idle = 1'b0;
    repeat (3) begin
      send_frame($urandom_range(0, 6), $urandom_range(0, 1), 1, -1);
      send_item(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_SLAVE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    mode      = 1'b0;
    rx_byte   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_short_frames();
    test_long_frame();
    test_stalled_output();
    test_random_traffic();
    test_full_rate();

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("modbus_rtu_read_master_framer: match");
    end else begin
      $display("modbus_rtu_read_master_framer: mismatch");
    end
    $finish;
  end

endmodule
